// File: sv/bvv_pkg.sv
// Package for the bencode value validator: word types, codes and constants.
package bvv_pkg;

    // Input word: one byte of the buffer and its end marker.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    // Result word: one for every input byte.
    typedef struct packed {
        logic [1:0] status;
        logic [2:0] error_kind;
        logic [7:0] nesting_level;
    } t_out_word;

    typedef enum logic [4:0] {
        PH_START      = 5'b00001,
        PH_INT_OPEN   = 5'b00010,
        PH_INT_DIGITS = 5'b00100,
        PH_STR_LEN    = 5'b01000,
        PH_STR_BODY   = 5'b10000
    } t_phase;

    localparam logic [1:0] ST_BUSY    = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_SYNTAX   = 3'd1;
    localparam logic [2:0] ERR_OVERFLOW = 3'd2;
    localparam logic [2:0] ERR_DEEP     = 3'd3;
    localparam logic [2:0] ERR_TRUNC    = 3'd4;

    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int         ACC_W          = 63;
    localparam logic [7:0] NEST_LIMIT     = 8'd255;
    localparam logic [7:0] MAX_DEPTH_RST  = 8'd32;
    // Largest accumulator value that may still take one more digit.
    localparam logic [ACC_W-1:0] ACC_LIMIT = 63'd922337203685477579;

endpackage

// File: sv/bencode_value_validator.sv
// Top level of the bencode value validator: byte pipeline, parser state and result register.
//
//   channel | direction | handshake                  | word
//   --------+-----------+----------------------------+------------------------------
//   in      | input     | i_in_valid / o_in_ready    | data_byte, last_byte
//   out     | output    | o_out_valid / i_out_ready  | status, error_kind, nesting_level
//   cfg     | input     | i_cfg_valid / o_cfg_ready  | max_depth
//
// A byte accepted at one edge sits in the input register while the parser step runs, and a
// later step loads its result into the result register, which then offers it. One byte
// is accepted per cycle while the output is not stalled.
// The parser state lives in a single set of registers updated by the step, so each byte
// sees the state left by the one before it. A stalled output holds the step and, once
// the input register is full, the input channel. Reset clears the pipeline and the
// parser state and sets max_depth to 32.
module bencode_value_validator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bvv_pkg::t_in_word  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bvv_pkg::t_out_word o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_max_depth
);

    logic                      r_in_valid;
    bvv_pkg::t_in_word         r_in;
    logic                      r_out_valid;
    bvv_pkg::t_out_word        r_out;
    logic [7:0]                r_max_depth;

    bvv_pkg::t_phase           r_phase, n_phase;
    logic [7:0]                r_open, n_open;
    // Holds the decimal value while a number is read, then the string bytes still due.
    logic [bvv_pkg::ACC_W-1:0] r_acc, n_acc;
    logic                      r_digit_seen, n_digit_seen;
    logic                      r_finished, n_finished;

    logic                      step;
    logic [7:0]                d;
    logic                      is_digit;
    logic                      acc_over;
    logic [bvv_pkg::ACC_W-1:0] acc_digit;
    logic [bvv_pkg::ACC_W-1:0] str_left;
    logic [1:0]                st;
    logic [2:0]                kind;

    assign step        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || step;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    assign d         = r_in.data_byte;
    assign is_digit  = (d >= bvv_pkg::CH_ZERO) && (d <= bvv_pkg::CH_NINE);
    assign acc_over  = r_acc > bvv_pkg::ACC_LIMIT;
    assign acc_digit = (r_acc << 3) + (r_acc << 1) + {{(bvv_pkg::ACC_W-4){1'b0}}, d[3:0]};
    assign str_left  = r_acc - {{(bvv_pkg::ACC_W-1){1'b0}}, (r_acc != '0)};

    always_comb begin
        n_phase      = r_phase;
        n_open       = r_open;
        n_acc        = r_acc;
        n_digit_seen = r_digit_seen;
        n_finished   = r_finished;
        st           = bvv_pkg::ST_BUSY;
        kind         = bvv_pkg::ERR_NONE;

        if (r_finished) begin
            st = bvv_pkg::ST_IGNORED;
        end else begin
            unique case (r_phase)
                bvv_pkg::PH_START: begin
                    if (r_open != 8'd0 && d == bvv_pkg::CH_E) begin
                        n_open = r_open - 8'd1;
                        st     = (n_open == 8'd0) ? bvv_pkg::ST_DONE : bvv_pkg::ST_BUSY;
                    end else if (r_open > r_max_depth) begin
                        st   = bvv_pkg::ST_ERROR;
                        kind = bvv_pkg::ERR_DEEP;
                    end else if (d == bvv_pkg::CH_I) begin
                        n_phase      = bvv_pkg::PH_INT_OPEN;
                        n_acc        = '0;
                        n_digit_seen = 1'b0;
                    end else if (d == bvv_pkg::CH_L || d == bvv_pkg::CH_D) begin
                        if (r_open >= bvv_pkg::NEST_LIMIT) begin
                            st   = bvv_pkg::ST_ERROR;
                            kind = bvv_pkg::ERR_DEEP;
                        end else begin
                            n_open = r_open + 8'd1;
                        end
                    end else if (is_digit) begin
                        n_acc        = {{(bvv_pkg::ACC_W-4){1'b0}}, d[3:0]};
                        n_digit_seen = 1'b1;
                        n_phase      = bvv_pkg::PH_STR_LEN;
                    end else begin
                        st   = bvv_pkg::ST_ERROR;
                        kind = bvv_pkg::ERR_SYNTAX;
                    end
                end
                bvv_pkg::PH_INT_OPEN, bvv_pkg::PH_INT_DIGITS: begin
                    n_phase = bvv_pkg::PH_INT_DIGITS;
                    if (r_phase == bvv_pkg::PH_INT_OPEN && d == bvv_pkg::CH_MINUS) begin
                        st = bvv_pkg::ST_BUSY;
                    end else if (is_digit) begin
                        if (acc_over) begin
                            st   = bvv_pkg::ST_ERROR;
                            kind = bvv_pkg::ERR_OVERFLOW;
                        end else begin
                            n_acc        = acc_digit;
                            n_digit_seen = 1'b1;
                        end
                    end else if (d == bvv_pkg::CH_E && r_digit_seen) begin
                        n_phase = bvv_pkg::PH_START;
                        st      = (r_open == 8'd0) ? bvv_pkg::ST_DONE : bvv_pkg::ST_BUSY;
                    end else begin
                        st   = bvv_pkg::ST_ERROR;
                        kind = bvv_pkg::ERR_SYNTAX;
                    end
                end
                bvv_pkg::PH_STR_LEN: begin
                    if (is_digit) begin
                        if (acc_over) begin
                            st   = bvv_pkg::ST_ERROR;
                            kind = bvv_pkg::ERR_OVERFLOW;
                        end else begin
                            n_acc        = acc_digit;
                            n_digit_seen = 1'b1;
                        end
                    end else if (d == bvv_pkg::CH_COLON) begin
                        if (r_acc == '0) begin
                            n_phase = bvv_pkg::PH_START;
                            st      = (r_open == 8'd0) ? bvv_pkg::ST_DONE : bvv_pkg::ST_BUSY;
                        end else begin
                            n_phase = bvv_pkg::PH_STR_BODY;
                        end
                    end else begin
                        st   = bvv_pkg::ST_ERROR;
                        kind = bvv_pkg::ERR_SYNTAX;
                    end
                end
                bvv_pkg::PH_STR_BODY: begin
                    n_acc = str_left;
                    if (str_left == '0) begin
                        n_phase = bvv_pkg::PH_START;
                        st      = (r_open == 8'd0) ? bvv_pkg::ST_DONE : bvv_pkg::ST_BUSY;
                    end
                end
                default: begin
                    st   = bvv_pkg::ST_ERROR;
                    kind = bvv_pkg::ERR_SYNTAX;
                end
            endcase
        end

        // A buffer that ends while the value is still open is truncated.
        if (st == bvv_pkg::ST_BUSY && r_in.last_byte) begin
            st   = bvv_pkg::ST_ERROR;
            kind = bvv_pkg::ERR_TRUNC;
        end

        if (st == bvv_pkg::ST_DONE || st == bvv_pkg::ST_ERROR) begin
            n_finished = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_max_depth  <= bvv_pkg::MAX_DEPTH_RST;
            r_phase      <= bvv_pkg::PH_START;
            r_open       <= 8'd0;
            r_acc        <= '0;
            r_digit_seen <= 1'b0;
            r_finished   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_max_depth <= i_cfg_max_depth;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (step) begin
                if (r_in.last_byte) begin
                    r_phase      <= bvv_pkg::PH_START;
                    r_open       <= 8'd0;
                    r_acc        <= '0;
                    r_digit_seen <= 1'b0;
                    r_finished   <= 1'b0;
                end else begin
                    r_phase      <= n_phase;
                    r_open       <= n_open;
                    r_acc        <= n_acc;
                    r_digit_seen <= n_digit_seen;
                    r_finished   <= n_finished;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (step) begin
            r_out.status        <= st;
            r_out.error_kind    <= kind;
            r_out.nesting_level <= n_open;
        end
    end

    a_kind_matches_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out.status == bvv_pkg::ST_ERROR) ==
                         (o_out.error_kind != bvv_pkg::ERR_NONE)))
        else $error("error kind disagrees with status");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_in.last_byte) |=>
            (r_open == 8'd0 && !r_finished && r_phase == bvv_pkg::PH_START))
        else $error("parser state not cleared after last byte");

    a_finished_ignores: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_finished) |=> (o_out.status == bvv_pkg::ST_IGNORED))
        else $error("byte after completion not ignored");

    a_level_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && !r_in.last_byte) |=> (o_out.nesting_level == r_open))
        else $error("reported nesting level differs from counter");

endmodule

// File: verif/tb_bencode_value_validator.sv
// Self-checking testbench for the bencode value validator: directed bytes, then random buffers.
module tb_bencode_value_validator;
    timeunit 1ns;
    timeprecision 1ps;

    import bvv_pkg::*;

    localparam int ITEMS_PER_PHASE = 480;
    localparam int QUIET_LIMIT     = 4000;

    typedef enum logic {ROW_BYTE, ROW_CFG} t_row_kind;
    typedef enum int {BUF_RANDOM, BUF_OVERFLOW, BUF_NEST_LIMIT} t_buf_kind;

    typedef struct packed {
        t_row_kind  kind;
        logic [7:0] data;      // byte to send, or the max_depth value for a config row
        logic       last;
        logic       typed;     // result is given in the row instead of predicted
        t_out_word  res;
    } t_row;

    localparam t_out_word NO_RES = '0;

    localparam t_row DIRECTED [0:22] = '{
        '{ROW_BYTE, CH_E,     1'b1, 1'b1, '{ST_ERROR, ERR_SYNTAX, 8'd0}},
        '{ROW_BYTE, CH_I,     1'b1, 1'b1, '{ST_ERROR, ERR_TRUNC, 8'd0}},
        '{ROW_BYTE, CH_I,     1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, CH_MINUS, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, CH_E,     1'b1, 1'b1, '{ST_ERROR, ERR_SYNTAX, 8'd0}},
        '{ROW_CFG,  8'd0,     1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, CH_L,     1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, CH_D,     1'b0, 1'b1, '{ST_ERROR, ERR_DEEP, 8'd1}},
        '{ROW_BYTE, 8'hFF,    1'b1, 1'b1, '{ST_IGNORED, ERR_NONE, 8'd1}},
        '{ROW_CFG,  8'd255,   1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, CH_D,     1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, 8'h31,    1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, CH_COLON, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, 8'h00,    1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, CH_I,     1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, CH_ZERO,  1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, CH_NINE,  1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, CH_E,     1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, CH_ZERO,  1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, CH_COLON, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, CH_E,     1'b0, 1'b1, '{ST_DONE, ERR_NONE, 8'd0}},
        '{ROW_BYTE, 8'hFF,    1'b0, 1'b1, '{ST_IGNORED, ERR_NONE, 8'd0}},
        '{ROW_BYTE, 8'h78,    1'b1, 1'b1, '{ST_IGNORED, ERR_NONE, 8'd0}}
    };

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_in_valid      = 1'b0;
    logic       o_in_ready;
    t_in_word   i_in            = '0;
    logic       o_out_valid;
    logic       i_out_ready     = 1'b0;
    t_out_word  o_out;
    logic       i_cfg_valid     = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_max_depth = '0;

    t_out_word pending_results [$];
    int        idle_pct     = 0;
    int        stall_pct    = 0;
    int        sent_items   = 0;
    int        fail_count   = 0;
    int        quiet_cycles = 0;

    // Parser state as the block should hold it.
    logic [7:0]       prs_max_depth  = MAX_DEPTH_RST;
    t_phase           prs_phase      = PH_START;
    logic [7:0]       prs_open       = '0;
    logic [ACC_W-1:0] prs_acc        = '0;
    logic [ACC_W-1:0] prs_left       = '0;
    logic             prs_digit_seen = 1'b0;
    logic             prs_finished   = 1'b0;

    bencode_value_validator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in            (i_in),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out           (o_out),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_max_depth (i_cfg_max_depth)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [1:0] close_element();
        prs_phase = PH_START;
        return (prs_open == 8'd0) ? ST_DONE : ST_BUSY;
    endfunction

    function automatic t_out_word parse_byte(input t_in_word w);
        logic [7:0] d;
        logic       is_num;
        logic       had_open;
        logic [1:0] st;
        logic [2:0] kind;
        t_out_word  res;
        d = w.data_byte;
        is_num = (d >= CH_ZERO) && (d <= CH_NINE);
        st = ST_ERROR;
        kind = ERR_SYNTAX;
        if (prs_finished) begin
            st = ST_IGNORED;
        end else begin
            case (prs_phase)
                PH_START: begin
                    if (prs_open != 8'd0 && d == CH_E) begin
                        prs_open = prs_open - 8'd1;
                        st = close_element();
                    end else if (prs_open > prs_max_depth) begin
                        kind = ERR_DEEP;
                    end else if (d == CH_I) begin
                        prs_phase = PH_INT_OPEN;
                        prs_acc = '0;
                        prs_digit_seen = 1'b0;
                        st = ST_BUSY;
                    end else if (d == CH_L || d == CH_D) begin
                        if (prs_open == NEST_LIMIT) begin
                            kind = ERR_DEEP;
                        end else begin
                            prs_open = prs_open + 8'd1;
                            st = ST_BUSY;
                        end
                    end else if (is_num) begin
                        prs_acc = ACC_W'(d - CH_ZERO);
                        prs_digit_seen = 1'b1;
                        prs_phase = PH_STR_LEN;
                        st = ST_BUSY;
                    end
                end
                PH_INT_OPEN, PH_INT_DIGITS, PH_STR_LEN: begin
                    // A sign is only allowed right after the opening 'i'.
                    had_open = (prs_phase == PH_INT_OPEN);
                    if (had_open) begin
                        prs_phase = PH_INT_DIGITS;
                    end
                    if (had_open && d == CH_MINUS) begin
                        st = ST_BUSY;
                    end else if (is_num) begin
                        if (prs_acc > ACC_LIMIT) begin
                            kind = ERR_OVERFLOW;
                        end else begin
                            prs_acc = prs_acc * 10 + ACC_W'(d - CH_ZERO);
                            prs_digit_seen = 1'b1;
                            st = ST_BUSY;
                        end
                    end else if (prs_phase == PH_INT_DIGITS) begin
                        if (d == CH_E && prs_digit_seen) begin
                            st = close_element();
                        end
                    end else if (d == CH_COLON) begin
                        if (prs_acc == '0) begin
                            st = close_element();
                        end else begin
                            prs_left = prs_acc;
                            prs_phase = PH_STR_BODY;
                            st = ST_BUSY;
                        end
                    end
                end
                PH_STR_BODY: begin
                    if (prs_left != '0) begin
                        prs_left = prs_left - 1;
                    end
                    if (prs_left == '0) begin
                        st = close_element();
                    end else begin
                        st = ST_BUSY;
                    end
                end
                default: ;
            endcase
        end
        if (st != ST_ERROR) begin
            kind = ERR_NONE;
        end
        if (st == ST_BUSY && w.last_byte) begin
            st = ST_ERROR;
            kind = ERR_TRUNC;
        end
        res.status = st;
        res.error_kind = kind;
        res.nesting_level = prs_open;
        if (w.last_byte) begin
            prs_phase = PH_START;
            prs_open = '0;
            prs_acc = '0;
            prs_left = '0;
            prs_digit_seen = 1'b0;
            prs_finished = 1'b0;
        end else if (st == ST_DONE || st == ST_ERROR) begin
            prs_finished = 1'b1;
        end
        return res;
    endfunction

    // Decimal digits; wide numbers sit around the point where the accumulator overflows.
    function automatic void push_number(ref logic [7:0] q[$], input bit wide);
        int    n;
        string lead;
        lead = "9223372036854775";
        if (wide ? ($urandom_range(1) == 0) : ($urandom_range(9) == 0)) begin
            for (int k = 0; k < lead.len(); k++) begin
                q.push_back(lead[k]);
            end
            n = $urandom_range(2, 4);
        end else if (wide) begin
            n = $urandom_range(17, 20);
        end else begin
            n = $urandom_range(1, 3);
        end
        repeat (n) q.push_back(CH_ZERO + 8'($urandom_range(9)));
    endfunction

    function automatic void push_scalar(ref logic [7:0] q[$]);
        int len;
        if ($urandom_range(1) == 1) begin
            q.push_back(CH_I);
            if ($urandom_range(2) == 0) begin
                q.push_back(CH_MINUS);
            end
            push_number(q, 1'b0);
            q.push_back(CH_E);
        end else begin
            len = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 5);
            if ($urandom_range(5) == 0) begin
                q.push_back(CH_ZERO);
            end
            if (len >= 10) begin
                q.push_back(CH_ZERO + 8'(len / 10));
            end
            q.push_back(CH_ZERO + 8'(len % 10));
            q.push_back(CH_COLON);
            repeat (len) q.push_back(8'($urandom_range(255)));
        end
    endfunction

    // Builds one value, dicts filled like lists; containers counted instead of recursion.
    function automatic void build_value(ref logic [7:0] q[$]);
        int open_n;
        int budget;
        int nest_cap;
        bit fin;
        open_n = 0;
        budget = $urandom_range(1, 8);
        nest_cap = $urandom_range(0, 4);
        fin = 1'b0;
        while (!fin) begin
            if (open_n > 0 && (budget == 0 || $urandom_range(3) == 0)) begin
                q.push_back(CH_E);
                open_n--;
                fin = (open_n == 0);
            end else begin
                if (budget > 0) begin
                    budget--;
                end
                if (open_n < nest_cap && $urandom_range(2) == 0) begin
                    q.push_back($urandom_range(1) ? CH_L : CH_D);
                    open_n++;
                end else begin
                    push_scalar(q);
                    fin = (open_n == 0);
                end
            end
        end
    endfunction

    function automatic void build_buffer(ref logic [7:0] q[$], input t_buf_kind kind);
        int    pick;
        int    n;
        string text;
        q.delete();
        pick = $urandom_range(99);
        if (kind == BUF_OVERFLOW) begin
            text = "i9223372036854775808e";
            for (int k = 0; k < text.len(); k++) begin
                q.push_back(text[k]);
            end
        end else if (kind == BUF_NEST_LIMIT) begin
            repeat (256) q.push_back(CH_L);
        end else if (pick < 5) begin
            repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(255)));
        end else if (pick < 10) begin
            if ($urandom_range(1) == 1) begin
                q.push_back(CH_I);
                push_number(q, 1'b1);
                q.push_back(CH_E);
            end else begin
                push_number(q, 1'b1);
                q.push_back(CH_COLON);
                repeat (3) q.push_back(8'($urandom_range(255)));
            end
        end else if (pick < 14) begin
            n = $urandom_range(1, 40);
            repeat (n) q.push_back(CH_L);
            repeat (n) q.push_back(CH_E);
        end else begin
            build_value(q);
            pick = $urandom_range(99);
            if (pick < 12 && q.size() > 1) begin
                repeat ($urandom_range(1, q.size() - 1)) void'(q.pop_back());
            end else if (pick < 22) begin
                q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(255));
            end else begin
                repeat ($urandom_range(0, 2)) q.push_back(8'($urandom_range(255)));
            end
        end
    endfunction

    task automatic feed_byte(input logic [7:0] b, input logic last, input logic typed,
                             input t_out_word typed_res);
        t_in_word  w;
        t_out_word r;
        w.data_byte = b;
        w.last_byte = last;
        i_in <= w;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        r = parse_byte(w);
        sent_items++;
        pending_results.push_back(typed ? typed_res : r);
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    // Stops sending and waits until every result is back and the pipeline is empty.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_max_depth(input logic [7:0] value);
        i_cfg_max_depth <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        prs_max_depth = value;
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                $display("%0t ns: result word with no byte pending, expected none, got %h",
                         $time, o_out);
            end else begin
                want = pending_results.pop_front();
                if (o_out.status !== want.status) begin
                    fail_count++;
                    $display("%0t ns: status expected %0d, got %0d",
                             $time, want.status, o_out.status);
                end
                if (o_out.error_kind !== want.error_kind) begin
                    fail_count++;
                    $display("%0t ns: error_kind expected %0d, got %0d",
                             $time, want.error_kind, o_out.error_kind);
                end
                if (o_out.nesting_level !== want.nesting_level) begin
                    fail_count++;
                    $display("%0t ns: nesting_level expected %0d, got %0d",
                             $time, want.nesting_level, o_out.nesting_level);
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_row       row;
        logic [7:0] bytes_q [$];
        bit         first;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[r]) begin
            row = DIRECTED[r];
            if (row.kind == ROW_CFG) begin
                settle();
                set_max_depth(row.data);
            end else begin
                feed_byte(row.data, row.last, row.typed, row.res);
            end
        end

        // Each phase starts from an empty pipeline with its own depth limit and idling mix.
        for (int ph = 0; ph < 4; ph++) begin
            settle();
            case (ph)
                0: begin
                    set_max_depth(MAX_DEPTH_RST);
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    set_max_depth(8'd255);
                    idle_pct = 76;
                    stall_pct = 0;
                end
                2: begin
                    set_max_depth(8'd1);
                    idle_pct = 0;
                    stall_pct = 76;
                end
                default: begin
                    set_max_depth(8'($urandom_range(2, 40)));
                    idle_pct = 32;
                    stall_pct = 32;
                end
            endcase
            sent_items = 0;
            first = 1'b1;
            while (sent_items < ITEMS_PER_PHASE) begin
                if (first && ph == 0) begin
                    build_buffer(bytes_q, BUF_OVERFLOW);
                end else if (first && ph == 1) begin
                    build_buffer(bytes_q, BUF_NEST_LIMIT);
                end else begin
                    build_buffer(bytes_q, BUF_RANDOM);
                end
                first = 1'b0;
                foreach (bytes_q[k]) begin
                    feed_byte(bytes_q[k], k == bytes_q.size() - 1, 1'b0, NO_RES);
                end
            end
        end

        idle_pct = 0;
        stall_pct = 0;
        settle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
